// ===== rtl/rgbrot_pkg.sv =====
`default_nettype none

package rgbrot_pkg;

	localparam int PIXEL_W    = 24;
	localparam int CFG_DATA_W = 9;
	localparam int CFG_IDX_W  = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_DRAIN = 1'b1
	} op_t;

	typedef logic [PIXEL_W-1:0] pixel_t;

endpackage

`default_nettype wire

// ===== rtl/rgbrot_if.sv =====
`default_nettype none

interface rgbrot_in_if import rgbrot_pkg::*; ();
	logic   valid;
	logic   ready;
	logic   operation;
	pixel_t pixel_in;

	modport source (output valid, output operation, output pixel_in, input ready);
	modport sink   (input valid, input operation, input pixel_in, output ready);
endinterface

interface rgbrot_out_if import rgbrot_pkg::*; ();
	logic   valid;
	logic   ready;
	pixel_t pixel_out;
	logic   frame_last;

	modport source (output valid, output pixel_out, output frame_last, input ready);
	modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/rgbrot_ram.sv =====
`default_nettype none

module rgbrot_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 65536
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/rgb24_frame_rotate_90.sv =====
// Frame store that turns one frame of 24-bit pixels by 90 degrees counter-clockwise.
// Throughput: one item (load or drain) per cycle unless the output stalls with a
// read pending; loads give no result. A drain result is registered by the frame
// store read and then by the output register before it is valid on the result port.
// Reset clears the load count and output valids, restarts the read cursor and
// restores the registers to 256x256 at most; the frame store itself is not cleared.
`default_nettype none

module rgb24_frame_rotate_90 import rgbrot_pkg::*; #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	rgbrot_in_if.sink                  request,
	rgbrot_out_if.source               result
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int LW    = $clog2(DEPTH + 1);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int RW    = $clog2(MAX_HEIGHT);
	localparam int RST_W = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
	localparam int RST_H = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;

	function automatic logic [WW-1:0] clamp_w(input logic [CFG_DATA_W-1:0] v);
		if (v == '0) begin
			return WW'(1);
		end else if (32'(v) > MAX_WIDTH) begin
			return WW'(MAX_WIDTH);
		end else begin
			return WW'(v);
		end
	endfunction

	function automatic logic [HW-1:0] clamp_h(input logic [CFG_DATA_W-1:0] v);
		if (v == '0) begin
			return HW'(1);
		end else if (32'(v) > MAX_HEIGHT) begin
			return HW'(MAX_HEIGHT);
		end else begin
			return HW'(v);
		end
	endfunction

	logic [WW-1:0] eff_w_q;
	logic [HW-1:0] eff_h_q;
	logic [LW-1:0] total_q;
	logic [LW-1:0] loaded_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [AW-1:0] addr_q;

	logic          valid_s1;
	logic          last_s1;
	logic          out_valid_q;
	pixel_t        pixel_q;
	logic          last_q;

	logic          complete;
	logic          xfer_in;
	logic          drain_fire;
	logic          load_fire;
	logic          move;
	logic          col_end;
	logic          is_last;
	logic [WW-1:0] new_w;
	logic [HW-1:0] new_h;
	logic [WW+HW-1:0] total_prod;
	logic [RW+WW-1:0] addr_prod;
	pixel_t        ram_rdata;

	assign complete   = loaded_q >= total_q;
	assign move       = valid_s1 && (!out_valid_q || result.ready);
	assign request.ready = !valid_s1 || !out_valid_q || result.ready;
	assign xfer_in    = request.valid && request.ready;
	assign drain_fire = xfer_in && (request.operation == OP_DRAIN) && complete;
	assign load_fire  = xfer_in && (request.operation == OP_LOAD) && !complete;

	assign col_end = (32'(row_q) + 32'd1) >= 32'(eff_h_q);
	assign is_last = col_end && (col_q == '0);

	assign new_w = clamp_w(cfg_data);
	assign new_h = clamp_h(cfg_data);

	always_comb begin
		unique case (cfg_reg_t'(cfg_index))
			REG_FRAME_WIDTH:  total_prod = new_w * eff_h_q;
			REG_FRAME_HEIGHT: total_prod = eff_w_q * new_h;
			default:          total_prod = '0;
		endcase
		// cursor address is row*width+column; rebuilt when the width changes
		addr_prod = row_q * new_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_w_q <= WW'(RST_W);
			eff_h_q <= HW'(RST_H);
			total_q <= LW'(RST_W * RST_H);
			loaded_q <= '0;
			col_q   <= CW'(RST_W - 1);
			row_q   <= '0;
			addr_q  <= AW'(RST_W - 1);
		end else begin
			if (cfg_we) begin
				total_q <= LW'(total_prod);
				unique case (cfg_reg_t'(cfg_index))
					REG_FRAME_WIDTH: begin
						eff_w_q <= new_w;
						addr_q  <= AW'(addr_prod) + AW'(col_q);
					end
					REG_FRAME_HEIGHT: begin
						eff_h_q <= new_h;
					end
					default: ;
				endcase
			end
			if (load_fire) begin
				loaded_q <= loaded_q + LW'(1);
				// cursor restarts on the first and on the final load of a frame
				if (loaded_q == '0 || (loaded_q + LW'(1)) == total_q) begin
					col_q  <= CW'(eff_w_q - WW'(1));
					row_q  <= '0;
					addr_q <= AW'(eff_w_q - WW'(1));
				end
			end else if (drain_fire) begin
				if (is_last) begin
					loaded_q <= '0;
					col_q    <= CW'(eff_w_q - WW'(1));
					row_q    <= '0;
					addr_q   <= AW'(eff_w_q - WW'(1));
				end else if (col_end) begin
					col_q  <= col_q - CW'(1);
					row_q  <= '0;
					addr_q <= AW'(col_q - CW'(1));
				end else begin
					row_q  <= row_q + RW'(1);
					addr_q <= addr_q + AW'(eff_w_q);
				end
			end
		end
	end

	rgbrot_ram #(
		.WIDTH (PIXEL_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (load_fire),
		.waddr (AW'(loaded_q)),
		.wdata (request.pixel_in),
		.re    (drain_fire),
		.raddr (addr_q),
		.rdata (ram_rdata)
	);

	// read data stays in the store's output register until it moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (drain_fire) begin
				valid_s1 <= 1'b1;
			end else if (move) begin
				valid_s1 <= 1'b0;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (drain_fire) begin
			last_s1 <= is_last;
		end
		if (move) begin
			pixel_q <= ram_rdata;
			last_q  <= last_s1;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.pixel_out  = pixel_q;
	assign result.frame_last = last_q;

	a_drain_reads: assert property (@(posedge clk) disable iff (!arst_n)
		drain_fire |=> valid_s1)
		else $error("drain transfer did not start a store read");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !result.ready |=> valid_s1 && $stable(last_s1))
		else $error("pending read lost under output stall");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(load_fire && drain_fire))
		else $error("store written and read in the same cycle");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result.ready |=> out_valid_q)
		else $error("result dropped while stalled");

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`default_nettype none

module tb;
	import rgbrot_pkg::*;

	localparam int MAX_W        = 256;
	localparam int MAX_H        = 256;
	localparam int STORE_DEPTH  = MAX_W * MAX_H;
	localparam int DRAIN_SETTLE = 4;
	localparam int HOLD_CYCLES  = 300;

	typedef struct packed {
		pixel_t px;
		logic   last;
	} rotated_px_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	rgbrot_in_if  req_if ();
	rgbrot_out_if res_if ();

	rgb24_frame_rotate_90 #(
		.MAX_WIDTH (MAX_W),
		.MAX_HEIGHT(MAX_H)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.request  (req_if),
		.result   (res_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	int send_idle_pct = 38;
	int recv_idle_pct = 57;
	bit hold_output   = 1'b0;
	int useful_items  = 0;
	int mismatch_count = 0;

	// predictor state
	logic [8:0]  reg_width, reg_height;
	logic [16:0] mdl_loaded;
	logic [7:0]  mdl_col, mdl_row;
	logic [15:0] mdl_addr;
	pixel_t      frame_mem [STORE_DEPTH];
	rotated_px_t rotated_q [$];

	function automatic logic [8:0] eff_dim(input logic [8:0] raw, input int max_dim);
		if (raw == 9'd0)
			return 9'd1;
		if (int'(raw) > max_dim)
			return 9'(max_dim);
		return raw;
	endfunction

	function automatic void restart_cursor(input logic [8:0] w);
		mdl_col  = 8'(w - 9'd1);
		mdl_row  = '0;
		mdl_addr = 16'(w - 9'd1);
	endfunction

	// returns 1 when the item was stored or produced a pixel
	function automatic bit predict_rotation(input op_t op, input pixel_t pix);
		logic [8:0]  w, h;
		logic [16:0] total;
		logic        col_end, last_px;
		rotated_px_t exp_px;
		w = eff_dim(reg_width, MAX_W);
		h = eff_dim(reg_height, MAX_H);
		total = 17'(w) * 17'(h);
		if (op == OP_LOAD) begin
			if (mdl_loaded >= total)
				return 1'b0;
			if (mdl_loaded == '0)
				restart_cursor(w);
			frame_mem[16'(mdl_loaded)] = pix;
			mdl_loaded++;
			if (mdl_loaded == total)
				restart_cursor(w);
			return 1'b1;
		end
		if (mdl_loaded < total)
			return 1'b0;
		mdl_addr = 16'(17'(mdl_row) * 17'(w) + 17'(mdl_col));
		col_end = (9'(mdl_row) + 9'd1) >= h;
		last_px = col_end && (mdl_col == '0);
		exp_px.px   = frame_mem[mdl_addr];
		exp_px.last = last_px;
		rotated_q.push_back(exp_px);
		if (last_px) begin
			mdl_loaded = '0;
			restart_cursor(w);
		end else if (col_end) begin
			mdl_row = '0;
			mdl_col--;
		end else begin
			mdl_row++;
		end
		return 1'b1;
	endfunction

	function automatic pixel_t random_pixel();
		return pixel_t'($urandom());
	endfunction

	function automatic logic [8:0] random_dim();
		if ($urandom_range(0, 9) == 0)
			return 9'd0;
		return 9'($urandom_range(1, 12));
	endfunction

	// result checker
	always @(posedge clk) begin
		rotated_px_t want;
		if (arst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
			if (rotated_q.size() == 0) begin
				$display("%0t: unexpected pixel %h last %b", $time,
					res_if.pixel_out, res_if.frame_last);
				mismatch_count++;
			end else begin
				want = rotated_q.pop_front();
				if (res_if.pixel_out !== want.px) begin
					$display("%0t: pixel_out expected %h actual %h", $time,
						want.px, res_if.pixel_out);
					mismatch_count++;
				end
				if (res_if.frame_last !== want.last) begin
					$display("%0t: frame_last expected %b actual %b", $time,
						want.last, res_if.frame_last);
					mismatch_count++;
				end
			end
		end
	end

	// output ready, with a long hold-off on request
	initial begin
		res_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_output) begin
				hold_output = 1'b0;
				res_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			res_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	task automatic send_item(input op_t op, input pixel_t pix);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid     <= 1'b1;
		req_if.operation <= op;
		req_if.pixel_in  <= pix;
		@(posedge clk);
		while (req_if.ready !== 1'b1)
			@(posedge clk);
		if (predict_rotation(op, pix))
			useful_items++;
	endtask

	task automatic wait_drained();
		req_if.valid <= 1'b0;
		while (rotated_q.size() != 0)
			@(posedge clk);
		// loads give no result but may still be in flight
		repeat (DRAIN_SETTLE) @(posedge clk);
	endtask

	task automatic set_frame_size(input logic [8:0] raw_w, input logic [8:0] raw_h);
		cfg_we    <= 1'b1;
		cfg_index <= REG_FRAME_WIDTH;
		cfg_data  <= raw_w;
		@(posedge clk);
		reg_width = raw_w;
		cfg_index <= REG_FRAME_HEIGHT;
		cfg_data  <= raw_h;
		@(posedge clk);
		reg_height = raw_h;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_frame(input logic [8:0] raw_w, input logic [8:0] raw_h,
			input bit noisy);
		int n_px;
		wait_drained();
		set_frame_size(raw_w, raw_h);
		n_px = int'(eff_dim(raw_w, MAX_W)) * int'(eff_dim(raw_h, MAX_H));
		for (int i = 0; i < n_px; i++) begin
			if (noisy && $urandom_range(0, 19) == 0)
				send_item(OP_DRAIN, random_pixel());
			send_item(OP_LOAD, random_pixel());
		end
		for (int i = 0; i < n_px; i++) begin
			// loads into a full frame are dropped
			if (noisy && $urandom_range(0, 19) == 0)
				send_item(OP_LOAD, random_pixel());
			send_item(OP_DRAIN, random_pixel());
		end
		if (noisy && $urandom_range(0, 3) == 0)
			send_item(OP_DRAIN, random_pixel());
	endtask

	task automatic test_early_drain();
		send_item(OP_DRAIN, 24'h000000);
		send_item(OP_DRAIN, 24'hFFFFFF);
	endtask

	task automatic test_single_pixel();
		wait_drained();
		set_frame_size(9'd0, 9'd0);
		send_item(OP_LOAD, 24'hFFFFFF);
		send_item(OP_LOAD, 24'h000000);
		send_item(OP_DRAIN, 24'h000000);
		send_item(OP_DRAIN, 24'hFFFFFF);
		send_item(OP_LOAD, 24'hA5C3E1);
		send_item(OP_DRAIN, 24'h000000);
	endtask

	task automatic test_small_frame();
		wait_drained();
		set_frame_size(9'd2, 9'd2);
		send_item(OP_LOAD, 24'h000000);
		send_item(OP_LOAD, 24'hFFFFFF);
		send_item(OP_LOAD, 24'h123456);
		send_item(OP_LOAD, 24'hEDCBA9);
		repeat (4) send_item(OP_DRAIN, random_pixel());
	endtask

	// shrink the frame after a partial load; cursor keeps the old start column
	task automatic test_resize_mid_frame();
		wait_drained();
		set_frame_size(9'd3, 9'd3);
		repeat (5) send_item(OP_LOAD, random_pixel());
		wait_drained();
		set_frame_size(9'd2, 9'd2);
		repeat (7) send_item(OP_DRAIN, random_pixel());
	endtask

	task automatic test_random_frames(input int budget);
		int first;
		first = useful_items;
		while (useful_items - first < budget)
			run_frame(random_dim(), random_dim(), 1'b1);
	endtask

	task automatic test_output_backpressure();
		wait_drained();
		hold_output = 1'b1;
		run_frame(9'd4, 9'd4, 1'b0);
	endtask

	// zero width acts as one, height above the maximum acts as the maximum
	task automatic test_extreme_sizes();
		run_frame(9'd0, 9'd511, 1'b1);
	endtask

	initial begin
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_index            = REG_FRAME_WIDTH;
		cfg_data             = '0;
		req_if.valid         = 1'b0;
		req_if.operation     = OP_LOAD;
		req_if.pixel_in      = '0;
		reg_width            = 9'd256;
		reg_height           = 9'd256;
		mdl_loaded           = '0;
		restart_cursor(9'd256);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 38;
		recv_idle_pct = 57;
		test_early_drain();
		test_single_pixel();
		test_small_frame();
		test_resize_mid_frame();
		test_random_frames(220);

		send_idle_pct = 57;
		recv_idle_pct = 38;
		test_random_frames(220);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_output_backpressure();
		test_extreme_sizes();
		test_random_frames(50);

		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && rotated_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire

// ===== rgb24_frame_rotate_90.f =====
rtl/rgbrot_pkg.sv
rtl/rgbrot_if.sv
rtl/rgbrot_ram.sv
rtl/rgb24_frame_rotate_90.sv
test/tb.sv
